// File: hw/rtl/box_blur_clamped_edges_unit_defines.svh
// Assertion macros for the box blur unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef BOX_BLUR_CLAMPED_EDGES_UNIT_DEFINES_SVH
`define BOX_BLUR_CLAMPED_EDGES_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/bbc_pkg.sv
// Shared constants, types and helper functions for the box blur unit.
// No dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int unsigned CH_N        = 4;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned PIX_W       = CH_N * CH_W;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned RAD_W       = 4;
  localparam int unsigned CRD_S_W     = 10;
  localparam int unsigned ADDR_W      = 2 * COORD_W;
  localparam int unsigned FRAME_DEPTH = 1 << ADDR_W;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned AREA_W      = 10;
  localparam int unsigned DIV_CNT_W   = 5;
  localparam int unsigned CH_IDX_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [DIM_W-1:0] MAX_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 9'd1;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [CRD_S_W-1:0] v,
                                                     input logic [DIM_W-1:0] size);
    logic signed [CRD_S_W-1:0] sz;
    logic [DIM_W-1:0]          lim;
    logic [COORD_W-1:0]        r;
    sz  = $signed({1'b0, size});
    lim = size - 9'd1;
    if (v < 0) begin
      r = '0;
    end else if (v >= sz) begin
      r = lim[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bbc_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bbc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all channels.
// Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bbc_pkg::SUM_W-1:0]  dividend_i,
  input  logic [bbc_pkg::AREA_W-1:0] divisor_i,
  output bbc_pkg::div_status_t       status_o,
  output logic [bbc_pkg::CH_W-1:0]   quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [bbc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [bbc_pkg::SUM_W-1:0]     dvd_q, dvd_d;
  logic [bbc_pkg::AREA_W-1:0]    rem_q, rem_d;
  logic [bbc_pkg::AREA_W:0]      rem_sh;
  logic [bbc_pkg::AREA_W:0]      rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_q, dvd_q[bbc_pkg::SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = bbc_pkg::DIV_CNT_W'(bbc_pkg::SUM_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[bbc_pkg::AREA_W-1:0] : rem_sh[bbc_pkg::AREA_W-1:0];
      dvd_d = {dvd_q[bbc_pkg::SUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == bbc_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q[bbc_pkg::CH_W-1:0];

endmodule

// File: hw/rtl/box_blur_clamped_edges_unit.sv
// Box blur with edge clamping over a 256x256 frame store of packed pixels.
// Depends on bbc_pkg, bbc_ram, bbc_div and the assertion macro header.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+------------
//   config  | cfg_index_i, cfg_data_i                   | valid/ready
//   input   | cmd_i, col_i, row_i, pixel_in_i           | valid/stall
//   output  | pixel_out_o                               | valid/stall
//
// A write goes straight to the frame store. A query makes one frame read per
// window pixel on the single read port, then four 18-step divisions on the
// shared divider. The result sits in an output register, so the next
// transaction is taken while it waits. Reset is asynchronous; the frame store
// holds no reset and needs no clearing.
`timescale 1ns / 1ps
`include "box_blur_clamped_edges_unit_defines.svh"

module box_blur_clamped_edges_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbc_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [bbc_pkg::COORD_W-1:0]   col_i,
  input  logic [bbc_pkg::COORD_W-1:0]   row_i,
  input  logic [bbc_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bbc_pkg::PIX_W-1:0]     pixel_out_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DIVW  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [bbc_pkg::RAD_W-1:0] radius_q;
  logic [bbc_pkg::DIM_W-1:0] width_q, height_q;

  logic signed [bbc_pkg::CRD_S_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [bbc_pkg::CRD_S_W-1:0] xs_q, xs_d, xe_q, xe_d, ye_q, ye_d;
  logic [bbc_pkg::AREA_W-1:0]         area_q, area_d;
  logic [bbc_pkg::SUM_W-1:0]          sum_q [bbc_pkg::CH_N];
  logic [bbc_pkg::CH_IDX_W-1:0]       ch_q, ch_d;
  logic [bbc_pkg::PIX_W-1:0]          res_q, res_d;
  logic                               rd_q;
  logic                               out_valid_q, out_valid_d;
  logic [bbc_pkg::PIX_W-1:0]          out_q;

  logic                          in_acc, is_query, wr_en, div_start, out_load;
  logic [bbc_pkg::COORD_W-1:0]   cx, cy;
  logic [bbc_pkg::DIM_W-1:0]     w_lim, h_lim;
  logic signed [bbc_pkg::CRD_S_W-1:0] cx_s, cy_s, r_s;
  logic [bbc_pkg::RAD_W:0]       side;
  logic [bbc_pkg::AREA_W-1:0]    area_new;
  logic [bbc_pkg::ADDR_W-1:0]    raddr;
  logic [bbc_pkg::PIX_W-1:0]     rdata;
  bbc_pkg::div_status_t          div_st;
  logic [bbc_pkg::CH_W-1:0]      quot;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_query    = (cmd_i == bbc_pkg::CMD_QUERY);
  assign wr_en       = in_acc && (cmd_i == bbc_pkg::CMD_WRITE) &&
                       ({1'b0, col_i} < width_q) && ({1'b0, row_i} < height_q);

  // centre clamp and window bounds
  assign w_lim    = width_q - 9'd1;
  assign h_lim    = height_q - 9'd1;
  assign cx       = ({1'b0, col_i} >= width_q)  ? w_lim[bbc_pkg::COORD_W-1:0] : col_i;
  assign cy       = ({1'b0, row_i} >= height_q) ? h_lim[bbc_pkg::COORD_W-1:0] : row_i;
  assign cx_s     = $signed({2'b00, cx});
  assign cy_s     = $signed({2'b00, cy});
  assign r_s      = $signed({6'b0, radius_q});
  assign side     = {radius_q, 1'b1};
  assign area_new = {5'b0, side} * {5'b0, side};

  assign raddr = {bbc_pkg::clamp_coord(y_q, height_q), bbc_pkg::clamp_coord(x_q, width_q)};

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    xs_d        = xs_q;
    xe_d        = xe_q;
    ye_d        = ye_q;
    area_d      = area_q;
    ch_d        = ch_q;
    res_d       = res_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          xs_d    = cx_s - r_s;
          x_d     = cx_s - r_s;
          y_d     = cy_s - r_s;
          xe_d    = cx_s + r_s;
          ye_d    = cy_s + r_s;
          area_d  = area_new;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (x_q == xe_q) begin
          x_d = xs_q;
          if (y_q == ye_q) begin
            state_d = ST_DRAIN;
          end else begin
            y_d = y_q + 10'sd1;
          end
        end else begin
          x_d = x_q + 10'sd1;
        end
      end
      ST_DRAIN: begin
        ch_d    = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_st.done) begin
          res_d[ch_q*bbc_pkg::CH_W +: bbc_pkg::CH_W] = quot;
          if (ch_q == bbc_pkg::CH_IDX_W'(bbc_pkg::CH_N - 1)) begin
            state_d = ST_FIN;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
      radius_q    <= '0;
      width_q     <= bbc_pkg::MAX_WIDTH;
      height_q    <= bbc_pkg::MAX_HEIGHT;
      ch_q        <= '0;
    end else begin
      state_q     <= state_d;
      rd_q        <= (state_q == ST_READ);
      out_valid_q <= out_valid_d;
      ch_q        <= ch_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bbc_pkg::REG_RADIUS: radius_q <= cfg_data_i[bbc_pkg::RAD_W-1:0];
          bbc_pkg::REG_WIDTH:  width_q  <= bbc_pkg::fit_dim(cfg_data_i, bbc_pkg::MAX_WIDTH);
          bbc_pkg::REG_HEIGHT: height_q <= bbc_pkg::fit_dim(cfg_data_i, bbc_pkg::MAX_HEIGHT);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    xs_q   <= xs_d;
    xe_q   <= xe_d;
    ye_q   <= ye_d;
    area_q <= area_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
    for (int i = 0; i < bbc_pkg::CH_N; i++) begin
      if (in_acc && is_query) begin
        sum_q[i] <= '0;
      end else if (rd_q) begin
        sum_q[i] <= sum_q[i] + bbc_pkg::SUM_W'(rdata[i*bbc_pkg::CH_W +: bbc_pkg::CH_W]);
      end
    end
  end

  bbc_ram #(
    .Width (bbc_pkg::PIX_W),
    .Depth (bbc_pkg::FRAME_DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i ({row_i, col_i}),
    .wdata_i (pixel_in_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[ch_q]),
    .divisor_i  (area_q),
    .status_o   (div_st),
    .quotient_o (quot)
  );

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_q;

  `BBC_ASSERT(a_div_start_free, clk_i, rst_ni, (state_q == ST_DIV) |-> !div_st.busy, "divider started while busy")
  `BBC_ASSERT(a_div_done_state, clk_i, rst_ni, div_st.done |-> (state_q == ST_DIVW), "division finished outside wait state")
  `BBC_ASSERT(a_fin_holds, clk_i, rst_ni, (state_q == ST_FIN && out_valid_q && out_stall_i) |=> (state_q == ST_FIN), "result overwrote a pending output")
  `BBC_ASSERT(a_read_in_window, clk_i, rst_ni, (state_q == ST_READ) |-> (y_q <= ye_q && x_q <= xe_q), "window walk left its bounds")

endmodule

// File: dv/testbench.sv
// Testbench for box_blur_clamped_edges_unit: pixel writes and blurred-pixel queries,
// predicted by an in-bench frame model and checked transaction by transaction.
// Depends on bbc_pkg and the box_blur_clamped_edges_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import bbc_pkg::*;

  localparam int FRAME_COLS     = 256;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pix;
  } pixel_req_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 cmd_i       = CMD_WRITE;
  logic [COORD_W-1:0]   col_i       = '0;
  logic [COORD_W-1:0]   row_i       = '0;
  logic [PIX_W-1:0]     pixel_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;

  // model of the block
  int               cur_radius = 0;
  int               cur_width  = 256;
  int               cur_height = 256;
  logic [PIX_W-1:0] frame_model [FRAME_DEPTH];
  bit               pix_written [FRAME_DEPTH];

  pixel_req_t       pending_requests [$];
  logic [PIX_W-1:0] blurred_expected [$];
  pixel_req_t       offered;
  logic [PIX_W-1:0] want_pixel;

  bit          idle_on = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          hold_left = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          stuck_cycles = 0;
  int unsigned error_count = 0;

  box_blur_clamped_edges_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int saturate_dim(input logic [DIM_W-1:0] v, input int limit);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > limit) begin
      return limit;
    end
    return int'(v);
  endfunction

  function automatic int clamp_axis(input int v, input int size);
    if (v < 0) begin
      return 0;
    end
    if (v >= size) begin
      return size - 1;
    end
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] blurred_pixel(input logic [COORD_W-1:0] col,
                                                     input logic [COORD_W-1:0] row);
    int               cx, cy, sx, sy, dx, dy, side, k;
    int unsigned      chan_sum [CH_N];
    logic [PIX_W-1:0] word;
    logic [PIX_W-1:0] res;
    cx = clamp_axis(int'(col), cur_width);
    cy = clamp_axis(int'(row), cur_height);
    for (k = 0; k < CH_N; k++) begin
      chan_sum[k] = 0;
    end
    for (dy = -cur_radius; dy <= cur_radius; dy++) begin
      sy = clamp_axis(cy + dy, cur_height);
      for (dx = -cur_radius; dx <= cur_radius; dx++) begin
        sx = clamp_axis(cx + dx, cur_width);
        word = frame_model[sy * FRAME_COLS + sx];
        for (k = 0; k < CH_N; k++) begin
          chan_sum[k] += word[k*CH_W +: CH_W];
        end
      end
    end
    side = 2 * cur_radius + 1;
    for (k = 0; k < CH_N; k++) begin
      res[k*CH_W +: CH_W] = CH_W'(chan_sum[k] / (side * side));
    end
    return res;
  endfunction

  // a query is legal only when every pixel its clamped window touches was stored
  function automatic bit window_ready(input int col, input int row);
    int cx, cy, dx, dy;
    cx = clamp_axis(col, cur_width);
    cy = clamp_axis(row, cur_height);
    for (dy = -cur_radius; dy <= cur_radius; dy++) begin
      for (dx = -cur_radius; dx <= cur_radius; dx++) begin
        if (!pix_written[clamp_axis(cy + dy, cur_height) * FRAME_COLS
                         + clamp_axis(cx + dx, cur_width)]) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    int pick;
    pick = $urandom_range(0, 4);
    if (pick == 0) begin
      return '1;
    end
    if (pick == 1) begin
      return '0;
    end
    return $urandom();
  endfunction

  task automatic plan_write(input int col, input int row, input logic [PIX_W-1:0] pix);
    pixel_req_t req;
    req = '{cmd: CMD_WRITE, col: COORD_W'(col), row: COORD_W'(row), pix: pix};
    pending_requests.push_back(req);
    if (col < cur_width && row < cur_height) begin
      pix_written[row * FRAME_COLS + col] = 1'b1;
    end
  endtask

  task automatic plan_query(input int col, input int row);
    pixel_req_t req;
    req = '{cmd: CMD_QUERY, col: COORD_W'(col), row: COORD_W'(row), pix: $urandom()};
    pending_requests.push_back(req);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_RADIUS: begin
        cur_radius = int'(data[RAD_W-1:0]);
      end
      REG_WIDTH: begin
        cur_width = saturate_dim(data, int'(MAX_WIDTH));
      end
      REG_HEIGHT: begin
        cur_height = saturate_dim(data, int'(MAX_HEIGHT));
      end
      default: begin
      end
    endcase
  endtask

  // the last item may be popped in the same step as the check, so check again after settling
  task automatic wait_idle();
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      while (pending_requests.size() != 0 || in_valid_i || blurred_expected.size() != 0) begin
        @(posedge clk_i);
      end
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      settled = (pending_requests.size() == 0) && !in_valid_i
                && (blurred_expected.size() == 0);
    end
  endtask

  task automatic set_geometry(input int rad, input int wdata, input int hdata);
    wait_idle();
    cfg_write(REG_RADIUS, {5'($urandom()), 4'(rad)});
    cfg_write(REG_WIDTH, DIM_W'(wdata));
    cfg_write(REG_HEIGHT, DIM_W'(hdata));
  endtask

  task automatic random_traffic(input int n, input int cw, input int ch, input int qpct);
    int i, tries, col, row;
    bit placed;
    for (i = 0; i < n; i++) begin
      placed = 1'b0;
      if ($urandom_range(0, 99) < qpct) begin
        for (tries = 0; tries < 8 && !placed; tries++) begin
          if ($urandom_range(0, 6) == 0) begin
            col = $urandom_range(0, 255);
            row = $urandom_range(0, 255);
          end else begin
            col = $urandom_range(0, cw - 1);
            row = $urandom_range(0, ch - 1);
          end
          if (window_ready(col, row)) begin
            plan_query(col, row);
            placed = 1'b1;
          end
        end
      end
      if (!placed) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            col = $urandom_range(0, 255);
            row = $urandom_range(0, 255);
          end
          2, 3: begin
            col = $urandom_range(0, cur_width - 1);
            row = $urandom_range(0, cur_height - 1);
          end
          default: begin
            col = $urandom_range(0, cw - 1);
            row = $urandom_range(0, ch - 1);
          end
        endcase
        plan_write(col, row, random_pixel());
      end
    end
  endtask

  task automatic run_phase(input int rad, input int wdata, input int hdata, input int cw,
                           input int ch, input int n, input int qpct, input bit idling,
                           input bit press);
    int c, r;
    set_geometry(rad, wdata, hdata);
    idle_on = idling;
    if (press) begin
      hold_requests++;
    end
    for (r = 0; r < ch; r++) begin
      for (c = 0; c < cw; c++) begin
        plan_write(c, r, random_pixel());
      end
    end
    random_traffic(n, cw, ch, qpct);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (offered.cmd == CMD_WRITE) begin
          if (int'(offered.col) < cur_width && int'(offered.row) < cur_height) begin
            frame_model[int'(offered.row) * FRAME_COLS + int'(offered.col)] = offered.pix;
          end
        end else begin
          blurred_expected.push_back(blurred_pixel(offered.col, offered.row));
        end
        in_gap = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          offered = pending_requests.pop_front();
          cmd_i      <= offered.cmd;
          col_i      <= offered.col;
          row_i      <= offered.row;
          pixel_in_i <= offered.pix;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (blurred_expected.size() == 0) begin
          $error("pixel_out: unexpected transaction, actual %h", pixel_out_o);
          error_count++;
        end else begin
          want_pixel = blurred_expected.pop_front();
          if (pixel_out_o !== want_pixel) begin
            $error("pixel_out: expected %h, actual %h", want_pixel, pixel_out_o);
            error_count++;
          end
        end
        out_gap = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("box_blur_clamped_edges_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: radius 0 over the full frame, both far corners
    plan_write(0, 0, 32'hFFFF_FFFF);
    plan_query(0, 0);
    plan_write(255, 255, 32'h0000_0000);
    plan_query(255, 255);
    plan_write(1, 0, 32'h1234_5678);
    plan_write(0, 1, 32'h8080_8080);
    plan_write(1, 1, 32'h7F00_FF01);
    plan_write(254, 254, 32'hFFFF_FFFF);
    plan_write(255, 254, 32'h0101_0101);
    plan_write(254, 255, 32'hFEDC_BA98);
    plan_query(1, 1);

    // radius 1 with windows clamped at both corners; spare register index
    wait_idle();
    cfg_write(REG_RADIUS, 9'h1F1);
    cfg_write(REG_WIDTH, 9'd256);
    cfg_write(REG_HEIGHT, 9'd256);
    cfg_write(REG_SPARE, 9'h1FF);
    plan_query(0, 0);
    plan_query(255, 255);

    // zero width acts as one, oversize height saturates, write outside is dropped
    wait_idle();
    cfg_write(REG_WIDTH, 9'd0);
    cfg_write(REG_HEIGHT, 9'h1FF);
    plan_write(1, 0, 32'h55AA_55AA);
    plan_query(200, 0);

    wait_idle();
    cfg_write(REG_WIDTH, 9'd256);
    cfg_write(REG_RADIUS, 9'h100);
    plan_query(1, 0);

    // largest radius over a 2x2 image, centre outside the image
    wait_idle();
    cfg_write(REG_RADIUS, 9'h00F);
    cfg_write(REG_WIDTH, 9'd2);
    cfg_write(REG_HEIGHT, 9'd2);
    plan_query(0, 0);
    plan_query(255, 255);

    run_phase(0, 256, 256, 6, 6, 60, 50, 1'b1, 1'b0);
    run_phase(2, 40, 30, 8, 6, 60, 50, 1'b0, 1'b0);
    run_phase(15, 3, 2, 3, 2, 15, 60, 1'b1, 1'b0);
    run_phase(1, 300, 7, 4, 7, 60, 60, 1'b1, 1'b1);
    run_phase(7, 9, 4, 9, 4, 35, 50, 1'b1, 1'b0);
    run_phase(3, 1, 256, 1, 10, 40, 50, 1'b0, 1'b0);
    run_phase(0, 256, 1, 16, 1, 40, 55, 1'b1, 1'b0);
    run_phase(15, 5, 4, 5, 4, 20, 60, 1'b1, 1'b0);
    run_phase(4, 64, 64, 6, 6, 50, 50, 1'b1, 1'b0);
    run_phase(0, 511, 0, 16, 1, 30, 60, 1'b1, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (blurred_expected.size() != 0) begin
      $error("pixel_out: expected %0d more transactions, actual 0", blurred_expected.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("box_blur_clamped_edges_unit test passed");
    end else begin
      $display("box_blur_clamped_edges_unit test failed");
    end
    $finish;
  end

endmodule
